// ===== design/mccdm_pkg.sv =====
package mccdm_pkg;

    // Field widths
    localparam int ChanW        = 4;
    localparam int CtrlW        = 7;
    localparam int ByteW        = 7;
    localparam int ValW         = 16;
    localparam int GainW        = 29;
    localparam int DacW         = 12;
    localparam int HitW         = 2;
    localparam int MatchW       = 19;
    localparam int CfgIdxW      = 4;
    localparam int CfgDataW     = 29;
    localparam int CombineShift = 8;
    localparam int FracW        = 16;
    localparam int ProdW        = ValW + GainW;
    localparam int WholeW       = ProdW - FracW;
    localparam int NumBytes     = 4;
    localparam int NumTargets   = 2;

    localparam logic [DacW-1:0] DacMax = {DacW{1'b1}};

    // Reset values of the target registers
    localparam logic [ValW-1:0]   MinReset   = ValW'(0);
    localparam logic [ValW-1:0]   MaxReset   = ValW'(127);
    localparam logic [GainW-1:0]  GainReset  = GainW'(2117632);
    localparam logic [MatchW-1:0] T1MatchRst = MatchW'(0);
    localparam logic [MatchW-1:0] T2MatchRst = MatchW'(1);

    typedef enum logic [HitW-1:0] {
        HIT_NONE = 2'd0,
        HIT_T1   = 2'd1,
        HIT_T2   = 2'd2
    } hit_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_T1_MATCH = 4'd0,
        REG_T1_MIN   = 4'd1,
        REG_T1_MAX   = 4'd2,
        REG_T1_GAIN  = 4'd3,
        REG_T2_MATCH = 4'd4,
        REG_T2_MIN   = 4'd5,
        REG_T2_MAX   = 4'd6,
        REG_T2_GAIN  = 4'd7
    } cfg_reg_t;

    // Packed match word: {fourteen, lsb_ctrl, msb_ctrl, chan}
    typedef struct packed {
        logic              fourteen;
        logic [CtrlW-1:0]  lsb_ctrl;
        logic [CtrlW-1:0]  msb_ctrl;
        logic [ChanW-1:0]  chan;
    } match_t;

    typedef struct packed {
        match_t            match;
        logic [ValW-1:0]   min_val;
        logic [ValW-1:0]   max_val;
        logic [GainW-1:0]  gain;
    } target_cfg_t;

    typedef struct packed {
        logic              cc;
        logic [ChanW-1:0]  chan;
        logic [CtrlW-1:0]  ctrl;
        logic [ByteW-1:0]  val;
    } msg_t;

    typedef struct packed {
        hit_t              hit;
        logic [ValW-1:0]   off;
        logic [GainW-1:0]  gain;
    } scale_req_t;

endpackage

// ===== design/mccdm_cfg_regs.sv =====
module mccdm_cfg_regs
    import mccdm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output target_cfg_t         t1_cfg,
    output target_cfg_t         t2_cfg
);

    target_cfg_t t1_reg;
    target_cfg_t t2_reg;

    // Hold the target settings; load one register per write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg.match   <= match_t'(T1MatchRst);
            t1_reg.min_val <= MinReset;
            t1_reg.max_val <= MaxReset;
            t1_reg.gain    <= GainReset;
            t2_reg.match   <= match_t'(T2MatchRst);
            t2_reg.min_val <= MinReset;
            t2_reg.max_val <= MaxReset;
            t2_reg.gain    <= GainReset;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_T1_MATCH: t1_reg.match   <= match_t'(cfg_data[MatchW-1:0]);
                REG_T1_MIN:   t1_reg.min_val <= cfg_data[ValW-1:0];
                REG_T1_MAX:   t1_reg.max_val <= cfg_data[ValW-1:0];
                REG_T1_GAIN:  t1_reg.gain    <= cfg_data[GainW-1:0];
                REG_T2_MATCH: t2_reg.match   <= match_t'(cfg_data[MatchW-1:0]);
                REG_T2_MIN:   t2_reg.min_val <= cfg_data[ValW-1:0];
                REG_T2_MAX:   t2_reg.max_val <= cfg_data[ValW-1:0];
                REG_T2_GAIN:  t2_reg.gain    <= cfg_data[GainW-1:0];
                default: ;
            endcase
        end
    end

    assign t1_cfg = t1_reg;
    assign t2_cfg = t2_reg;

endmodule

// ===== design/mccdm_decode.sv =====
module mccdm_decode
    import mccdm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        commit,
    input  msg_t        msg,
    input  target_cfg_t t1_cfg,
    input  target_cfg_t t2_cfg,
    output scale_req_t  req
);

    logic [ByteW-1:0] bytes_reg  [NumBytes];
    logic [ByteW-1:0] bytes_next [NumBytes];
    logic [ValW-1:0]  last_reg   [NumTargets];
    logic [ValW-1:0]  last_next  [NumTargets];

    target_cfg_t      tc [NumTargets];
    target_cfg_t      sel_cfg;
    logic             done;
    logic             sel_t;
    hit_t             hit;
    logic [ValW-1:0]  sel_val;
    logic [ValW-1:0]  comb;
    logic [ValW-1:0]  floored;
    logic [ValW-1:0]  clamped;
    logic [ValW-1:0]  off;

    assign tc[0] = t1_cfg;
    assign tc[1] = t2_cfg;

    // Walk the checks in priority order: T1 MSB, T1 LSB, T2 MSB, T2 LSB
    always_comb begin
        bytes_next = bytes_reg;
        last_next  = last_reg;
        done       = 1'b0;
        sel_t      = 1'b0;
        hit        = HIT_NONE;
        sel_val    = '0;
        comb       = '0;
        if (msg.cc) begin
            for (int t = 0; t < NumTargets; t++) begin
                if (!done && msg.chan == tc[t].match.chan) begin
                    if (msg.ctrl == tc[t].match.msb_ctrl) begin
                        bytes_next[2*t] = msg.val;
                        if (!tc[t].match.fourteen) begin
                            done    = 1'b1;
                            sel_t   = (t != 0);
                            hit     = (t == 0) ? HIT_T1 : HIT_T2;
                            sel_val = ValW'(msg.val);
                        end
                    end
                    if (!done && msg.ctrl == tc[t].match.lsb_ctrl) begin
                        bytes_next[2*t+1] = msg.val;
                        comb = (ValW'(bytes_next[2*t]) << CombineShift)
                             | ValW'(bytes_next[2*t+1]);
                        if (comb != last_reg[t]) begin
                            last_next[t] = comb;
                            done         = 1'b1;
                            sel_t        = (t != 0);
                            hit          = (t == 0) ? HIT_T1 : HIT_T2;
                            sel_val      = comb;
                        end
                    end
                end
            end
        end
    end

    // Clamp to floor then ceiling, then remove the floor
    always_comb begin
        sel_cfg = sel_t ? t2_cfg : t1_cfg;
        floored = (sel_val < sel_cfg.min_val) ? sel_cfg.min_val : sel_val;
        clamped = (floored > sel_cfg.max_val) ? sel_cfg.max_val : floored;
        off     = (clamped >= sel_cfg.min_val) ? (clamped - sel_cfg.min_val) : '0;
        req.hit  = hit;
        req.off  = (hit == HIT_NONE) ? '0 : off;
        req.gain = sel_cfg.gain;
    end

    // Advance the byte and repeat-suppression state when the transaction moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NumBytes; i++) begin
                bytes_reg[i] <= '0;
            end
            for (int i = 0; i < NumTargets; i++) begin
                last_reg[i] <= '0;
            end
        end else if (commit) begin
            bytes_reg <= bytes_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ===== design/mccdm_scale.sv =====
module mccdm_scale
    import mccdm_pkg::*;
(
    input  scale_req_t      req,
    output logic [HitW-1:0] hit,
    output logic [DacW-1:0] dac
);

    logic [ProdW-1:0]  prod;
    logic [WholeW-1:0] whole;

    // Multiply by the Q13.16 gain, drop the fraction, saturate at full scale
    always_comb begin
        prod  = ProdW'(req.off) * ProdW'(req.gain);
        whole = prod[ProdW-1:FracW];
        dac   = (|whole[WholeW-1:DacW]) ? DacMax : whole[DacW-1:0];
        hit   = req.hit;
    end

endmodule

// ===== design/midi_cc_to_dac_mapper_top.sv =====
// Channel  | Handshake         | Payload
// ---------+-------------------+--------------------------------------------------
// input    | s_valid / s_ready | s_is_control_change, s_midi_channel,
//          |                   | s_controller_number, s_controller_value
// result   | m_valid / m_ready | m_target_hit, m_dac_value
// config   | cfg_wr_en         | cfg_index, cfg_data (no wait, no read-back)
//
// One message per cycle sustained while m_ready is high; each result passes through
// the input register, the match/clamp stage and the multiply/saturate stage.
// Match state (stored bytes, last values) updates as a message leaves the input
// register, so the next message sees it at once.
// Synchronous active-low reset clears the valids and the match state and loads the config reset values.
// A stalled m_ready holds the result and backs the pipeline up to s_ready.
module midi_cc_to_dac_mapper_top
    import mccdm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_is_control_change,
    input  logic [ChanW-1:0]    s_midi_channel,
    input  logic [CtrlW-1:0]    s_controller_number,
    input  logic [ByteW-1:0]    s_controller_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [HitW-1:0]     m_target_hit,
    output logic [DacW-1:0]     m_dac_value,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    target_cfg_t     t1_cfg;
    target_cfg_t     t2_cfg;
    msg_t            msg_reg;
    logic            in_v_reg;
    scale_req_t      req;
    scale_req_t      req_reg;
    logic            mid_v_reg;
    logic [HitW-1:0] hit_s;
    logic [DacW-1:0] dac_s;
    logic [HitW-1:0] hit_reg;
    logic [DacW-1:0] dac_reg;
    logic            out_v_reg;
    logic            out_load;
    logic            mid_load;
    logic            in_load;

    mccdm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .t1_cfg    (t1_cfg),
        .t2_cfg    (t2_cfg)
    );

    // Stage enables: each stage loads when it is empty or its successor loads
    assign out_load = !out_v_reg || m_ready;
    assign mid_load = !mid_v_reg || out_load;
    assign in_load  = !in_v_reg || mid_load;
    assign s_ready  = in_load;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (in_load) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && s_valid) begin
            msg_reg.cc   <= s_is_control_change;
            msg_reg.chan <= s_midi_channel;
            msg_reg.ctrl <= s_controller_number;
            msg_reg.val  <= s_controller_value;
        end
    end

    mccdm_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (in_v_reg && mid_load),
        .msg     (msg_reg),
        .t1_cfg  (t1_cfg),
        .t2_cfg  (t2_cfg),
        .req     (req)
    );

    // Middle register: target, offset value and gain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_v_reg <= 1'b0;
        end else if (mid_load) begin
            mid_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_load && in_v_reg) begin
            req_reg <= req;
        end
    end

    mccdm_scale u_scale (
        .req (req_reg),
        .hit (hit_s),
        .dac (dac_s)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_load) begin
            out_v_reg <= mid_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && mid_v_reg) begin
            hit_reg <= hit_s;
            dac_reg <= dac_s;
        end
    end

    assign m_valid      = out_v_reg;
    assign m_target_hit = hit_reg;
    assign m_dac_value  = dac_reg;

endmodule

// ===== design/mccdm_checker.sv =====
module mccdm_checker
    import mccdm_pkg::*;
(
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input logic [HitW-1:0] m_target_hit,
    input logic [DacW-1:0] m_dac_value
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_target_hit) && $stable(m_dac_value))
        else $error("result changed while stalled");

    // The target code is none, target one or target two
    a_hit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_target_hit == HIT_NONE || m_target_hit == HIT_T1
                    || m_target_hit == HIT_T2)
        else $error("target code out of range");

    // No target means a zero code
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_target_hit == HIT_NONE |-> m_dac_value == '0)
        else $error("nonzero code without a target");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // An empty pipeline takes input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && $past(!m_valid) && $past(!s_valid) && $past(!s_valid, 2)
        && $past(!s_valid, 3) |-> s_ready)
        else $error("input stalled with an empty pipeline");

endmodule

bind midi_cc_to_dac_mapper_top mccdm_checker u_mccdm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_target_hit (m_target_hit),
    .m_dac_value  (m_dac_value)
);
